### hdl/tcu_pkg.sv
// ----------------------------------------------------------------------------
// tcu_pkg
// Shared types, constants and log table for the thermistor temperature chain.
// ----------------------------------------------------------------------------
package tcu_pkg;

   // register map, index = paddr[5:3]
   localparam int         CFG_ADDR_W   = 6;
   localparam logic [2:0] REG_SUPPLY   = 3'd0;
   localparam logic [2:0] REG_SERIES   = 3'd1;
   localparam logic [2:0] REG_COEFF_A  = 3'd2;
   localparam logic [2:0] REG_COEFF_B  = 3'd3;
   localparam logic [2:0] REG_COEFF_C  = 3'd4;
   localparam logic [2:0] REG_ALPHA    = 3'd5;

   typedef struct packed {
      logic [11:0] supply_mv;
      logic [19:0] series_ohms;
      logic [39:0] coeff_a;
      logic [39:0] coeff_b;
      logic [39:0] coeff_c;
      logic [16:0] filter_alpha;
   } cfg_type;

   localparam logic [11:0] SUPPLY_RST  = 12'd3350;
   localparam logic [19:0] SERIES_RST  = 20'd10000;
   localparam logic [39:0] COEFF_A_RST = 40'd317815219012;
   localparam logic [39:0] COEFF_B_RST = 40'd65902200000;
   localparam logic [39:0] COEFF_C_RST = 40'd24678000;
   localparam logic [16:0] ALPHA_RST   = 17'd6554;

   localparam logic [19:0] R_MIN = 20'd100;
   localparam logic [19:0] R_MAX = 20'd1000000;

   localparam logic [63:0]        TEMP_LIMIT_HI     = 64'd17339186;  // offset + max
   localparam logic signed [25:0] KELVIN_OFFSET_Q15 = 26'sd8950579;
   localparam logic signed [23:0] TEMP_MAX          = 24'sh7FFFFF;
   localparam logic signed [23:0] TEMP_MIN          = 24'sh800000;
   localparam logic [16:0]        ALPHA_ONE         = 17'd65536;

   localparam logic [31:0] DIV3_RECIP = 32'hAAAAAAAB;  // ceil(2^33/3)
   localparam logic [63:0] RECIP_NUM  = 64'h8000000000000000;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DEN, ST_RDIV, ST_RCLAMP, ST_LNINIT, ST_NORM, ST_LNSTEP,
      ST_V, ST_MV2, ST_MV3, ST_MD3, ST_LNFIN, ST_MSQ, ST_MCU, ST_MB, ST_MC,
      ST_INV, ST_TDIV, ST_TEMP, ST_FMUL, ST_FADD, ST_OUT
   } back_state_type;

   // elaboration-time long division, used only to build the log table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dsr);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, dsr}) begin
            rem    = rem - {1'b0, dsr};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ln((d+1)/(d-1)) in Q32 via the atanh series
   function automatic logic [63:0] ln_ratio(input logic [63:0] d);
      logic [63:0] p;
      logic [63:0] dd;
      logic [63:0] acc;
      p   = udiv64(64'h4000000000000000, d);
      dd  = d * d;
      acc = '0;
      for (int n = 0; n < 64; n++) begin
         if (p != '0) begin
            acc = acc + udiv64(p, 64'(2 * n + 1));
            p   = udiv64(p, dd);
         end
      end
      return (64'd2 * acc + 64'h20000000) >> 30;
   endfunction

   localparam int LN_STEPS = 8;

   // entry 0: ln 2, entry k: ln(1 + 2^-k)
   localparam logic [63:0] LN_ROM [0:LN_STEPS] = '{
      ln_ratio(64'd3),   ln_ratio(64'd5),   ln_ratio(64'd9),
      ln_ratio(64'd17),  ln_ratio(64'd33),  ln_ratio(64'd65),
      ln_ratio(64'd129), ln_ratio(64'd257), ln_ratio(64'd513)
   };

endpackage

### hdl/tcu_front.sv
// ----------------------------------------------------------------------------
// tcu_front
// Sample window and running sum; queues the sum once the window is full.
// ----------------------------------------------------------------------------
module tcu_front import tcu_pkg::*; #(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 12,
   parameter int SUM_W       = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   queue_full,
   output logic                   queue_wr,
   output logic [SUM_W-1:0]       queue_data
);

   localparam int FILL_W = $clog2(WINDOW + 1);

   logic [SAMPLE_BITS-1:0] win_ff [WINDOW];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   accept;
   logic                   win_full;

   assign accept   = push && !queue_full;
   assign win_full = (fill_ff == FILL_W'(WINDOW));

   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (accept) begin
         if (!win_full) fill_in = fill_ff + 1'b1;
         sum_in = sum_ff - (win_full ? SUM_W'(win_ff[WINDOW-1]) : '0) + SUM_W'(sample);
      end
   end

   assign queue_wr   = accept && (fill_in == FILL_W'(WINDOW));
   assign queue_data = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   // shift line: tap WINDOW-1 is the sample leaving the window
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= sample;
         for (int i = 1; i < WINDOW; i++) win_ff[i] <= win_ff[i-1];
      end
   end

endmodule

### hdl/tcu_fifo.sv
// ----------------------------------------------------------------------------
// tcu_fifo
// Short queue of window sums between front and back.
// ----------------------------------------------------------------------------
module tcu_fifo import tcu_pkg::*; #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0]      mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [FIFO_PTR_W:0]   cnt_ff, cnt_in;
   logic                  do_wr, do_rd;

   assign full    = (cnt_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (do_wr && !do_rd) cnt_in = cnt_ff + 1'b1;
      if (!do_wr && do_rd) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

endmodule

### hdl/tcu_back.sv
// ----------------------------------------------------------------------------
// tcu_back
// Sequencer: resistance divide, log, Steinhart-Hart, reciprocal and filter.
// ----------------------------------------------------------------------------
module tcu_back import tcu_pkg::*; #(
   parameter int WINDOW = 10,
   parameter int SUM_W  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             fifo_empty,
   input  logic [SUM_W-1:0] fifo_data,
   output logic             fifo_rd,
   input  logic             rsp_pop,
   output logic             rsp_valid,
   output logic [16:0]      rsp_temp,
   output logic [19:0]      rsp_res,
   output logic             rsp_clamp
);

   localparam int SUPW  = 12 + $clog2(WINDOW + 1);
   localparam int DEN_W = ((SUM_W > SUPW) ? SUM_W : SUPW) + 1;
   localparam int NUM_W = SUM_W + 20;

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [19:0]      res_ff, res_in;
   logic             clamp_ff, clamp_in;
   logic [31:0]      m_ff, m_in;
   logic [4:0]       e_ff, e_in;
   logic [3:0]       k_ff, k_in;
   logic [32:0]      lnacc_ff, lnacc_in;
   logic [31:0]      v_ff, v_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [35:0]      lnr_ff, lnr_in;
   logic [39:0]      sq_ff, sq_in;
   logic [43:0]      l3_ff, l3_in, tb_ff, tb_in;
   logic [51:0]      tc_ff, tc_in;
   logic signed [23:0] c_ff, c_in, filt_ff, filt_in;
   logic signed [42:0] prod_ff, prod_in;
   logic             out_valid_ff, out_valid_in;
   logic [16:0]      out_temp_ff, out_temp_in;
   logic [19:0]      out_res_ff, out_res_in;
   logic             out_clamp_ff, out_clamp_in;

   // shared shift-subtract divider
   logic [63:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [55:0] rem_ff, rem_in;
   logic [56:0] rem_sh;
   logic [55:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        div_ge;

   // shared 32x32 multiplier, four partial products per operation
   logic [1:0]  mph_ff, mph_in;
   logic [95:0] macc_ff, macc_in, msum, pp_sh;
   logic [47:0] mul_a, mul_b;
   logic [31:0] op_x, op_y;
   logic [63:0] pp;
   logic        is_mul;

   logic [SUPW-1:0]         scaled_supply;
   logic signed [DEN_W-1:0] den;
   logic [NUM_W-1:0]        num;
   logic [32:0]             step_t;
   logic [37:0]             ln_full;
   logic [55:0]             inv_sum;
   logic signed [25:0]      c_diff;
   logic signed [24:0]      d_s;
   logic [16:0]             alpha_eff;
   logic signed [42:0]      prod_rnd;
   logic signed [26:0]      step_v;
   logic signed [27:0]      y_sum;
   logic                    out_free;

   assign scaled_supply = SUPW'(WINDOW) * SUPW'(cfg.supply_mv);
   assign den = $signed(DEN_W'(scaled_supply)) - $signed(DEN_W'(sum_ff));
   assign num = NUM_W'(sum_ff) * NUM_W'(cfg.series_ohms);

   assign rem_sh = {rem_ff, dvd_ff[63]};
   assign div_ge = (rem_sh >= {1'b0, dsr_ff});

   assign is_mul = (state_ff inside {ST_MV2, ST_MV3, ST_MD3, ST_MSQ, ST_MCU, ST_MB, ST_MC});

   always_comb begin
      case (state_ff)
         ST_MV2:  begin mul_a = 48'(v_ff);        mul_b = 48'(v_ff);       end
         ST_MV3:  begin mul_a = 48'(v2_ff);       mul_b = 48'(v_ff);       end
         ST_MD3:  begin mul_a = 48'(v3_ff);       mul_b = 48'(DIV3_RECIP); end
         ST_MSQ:  begin mul_a = 48'(lnr_ff);      mul_b = 48'(lnr_ff);     end
         ST_MCU:  begin mul_a = 48'(sq_ff);       mul_b = 48'(lnr_ff);     end
         ST_MB:   begin mul_a = 48'(cfg.coeff_b); mul_b = 48'(lnr_ff);     end
         ST_MC:   begin mul_a = 48'(cfg.coeff_c); mul_b = 48'(l3_ff);      end
         default: begin mul_a = '0;               mul_b = '0;              end
      endcase
   end

   always_comb begin
      case (mph_ff)
         2'd0:    begin op_x = mul_a[31:0];         op_y = mul_b[31:0];         end
         2'd1:    begin op_x = 32'(mul_a[47:32]);   op_y = mul_b[31:0];         end
         2'd2:    begin op_x = mul_a[31:0];         op_y = 32'(mul_b[47:32]);   end
         default: begin op_x = 32'(mul_a[47:32]);   op_y = 32'(mul_b[47:32]);   end
      endcase
   end

   assign pp = 64'(op_x) * 64'(op_y);

   always_comb begin
      case (mph_ff)
         2'd0:    pp_sh = 96'(pp);
         2'd1,
         2'd2:    pp_sh = 96'(pp) << 32;
         default: pp_sh = 96'(pp) << 64;
      endcase
   end

   assign msum = ((mph_ff == 2'd0) ? 96'd0 : macc_ff) + pp_sh;

   assign step_t    = {1'b0, m_ff} + {1'b0, m_ff >> k_ff};
   assign ln_full   = 38'(6'(e_ff) + 6'd1) * 38'(LN_ROM[0][31:0])
                      - 38'(lnacc_ff) - 38'(v_ff) - 38'(v2_ff >> 1) - 38'(v3_ff);
   assign inv_sum   = 56'(cfg.coeff_a) + 56'(tb_ff) + 56'(tc_ff);
   assign c_diff    = $signed({1'b0, quo_ff[24:0]}) - KELVIN_OFFSET_Q15;
   assign d_s       = 25'(c_ff) - 25'(filt_ff);
   assign alpha_eff = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
   assign prod_rnd  = prod_ff + 43'sd32768;
   assign step_v    = 27'(prod_rnd >>> 16);
   assign y_sum     = 28'(filt_ff) + 28'(step_v);
   assign out_free  = !out_valid_ff || rsp_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (!fifo_empty) state_in = ST_DEN;
         ST_DEN:    state_in = (den <= 0) ? ST_LNINIT : ST_RDIV;
         ST_RDIV:   if (cnt_ff == 6'd63) state_in = ST_RCLAMP;
         ST_RCLAMP: state_in = ST_LNINIT;
         ST_LNINIT: state_in = ST_NORM;
         ST_NORM:   if (m_ff[31]) state_in = ST_LNSTEP;
         ST_LNSTEP: if (k_ff == 4'(LN_STEPS)) state_in = ST_V;
         ST_V:      state_in = ST_MV2;
         ST_MV2:    if (mph_ff == 2'd3) state_in = ST_MV3;
         ST_MV3:    if (mph_ff == 2'd3) state_in = ST_MD3;
         ST_MD3:    if (mph_ff == 2'd3) state_in = ST_LNFIN;
         ST_LNFIN:  state_in = ST_MSQ;
         ST_MSQ:    if (mph_ff == 2'd3) state_in = ST_MCU;
         ST_MCU:    if (mph_ff == 2'd3) state_in = ST_MB;
         ST_MB:     if (mph_ff == 2'd3) state_in = ST_MC;
         ST_MC:     if (mph_ff == 2'd3) state_in = ST_INV;
         ST_INV:    state_in = (inv_sum == '0) ? ST_OUT : ST_TDIV;
         ST_TDIV:   if (cnt_ff == 6'd63) state_in = ST_TEMP;
         ST_TEMP:   state_in = ST_FMUL;
         ST_FMUL:   state_in = ST_FADD;
         ST_FADD:   state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      fifo_rd  = 1'b0;
      sum_in   = sum_ff;   res_in  = res_ff;   clamp_in = clamp_ff;
      m_in     = m_ff;     e_in    = e_ff;     k_in     = k_ff;
      lnacc_in = lnacc_ff; v_in    = v_ff;     v2_in    = v2_ff;   v3_in = v3_ff;
      lnr_in   = lnr_ff;   sq_in   = sq_ff;    l3_in    = l3_ff;
      tb_in    = tb_ff;    tc_in   = tc_ff;    c_in     = c_ff;
      prod_in  = prod_ff;  filt_in = filt_ff;
      dvd_in   = dvd_ff;   quo_in  = quo_ff;   rem_in   = rem_ff;
      dsr_in   = dsr_ff;   cnt_in  = cnt_ff;
      mph_in   = is_mul ? mph_ff + 1'b1 : 2'd0;
      macc_in  = is_mul ? msum : macc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_temp_in  = out_temp_ff;
      out_res_in   = out_res_ff;
      out_clamp_in = out_clamp_ff;

      case (state_ff)
         ST_IDLE: begin
            fifo_rd = !fifo_empty;
            sum_in  = fifo_data;
         end
         ST_DEN: begin
            if (den == 0) begin
               res_in = R_MAX; clamp_in = 1'b1;
            end else if (den < 0) begin
               res_in = R_MIN; clamp_in = 1'b1;
            end else begin
               dvd_in = 64'(num);
               dsr_in = 56'(den);
               rem_in = '0;
               cnt_in = '0;
            end
         end
         ST_RDIV, ST_TDIV: begin
            rem_in = div_ge ? 56'(rem_sh - {1'b0, dsr_ff}) : rem_sh[55:0];
            dvd_in = {dvd_ff[62:0], 1'b0};
            quo_in = {quo_ff[62:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_RCLAMP: begin
            if (quo_ff < 64'(R_MIN)) begin
               res_in = R_MIN; clamp_in = 1'b1;
            end else if (quo_ff > 64'(R_MAX)) begin
               res_in = R_MAX; clamp_in = 1'b1;
            end else begin
               res_in = quo_ff[19:0]; clamp_in = 1'b0;
            end
         end
         ST_LNINIT: begin
            m_in     = {res_ff, 12'd0};
            e_in     = 5'd19;
            k_in     = 4'd1;
            lnacc_in = '0;
         end
         ST_NORM: begin
            if (!m_ff[31]) begin
               m_in = m_ff << 1;
               e_in = e_ff - 1'b1;
            end
         end
         ST_LNSTEP: begin
            if (!step_t[32]) begin
               m_in     = step_t[31:0];
               lnacc_in = lnacc_ff + 33'(LN_ROM[k_ff][31:0]);
            end
            k_in = k_ff + 1'b1;
         end
         ST_V:     v_in = 32'(33'h100000000 - 33'(m_ff));
         ST_MV2:   if (mph_ff == 2'd3) v2_in = msum[63:32];
         ST_MV3:   if (mph_ff == 2'd3) v3_in = msum[63:32];
         ST_MD3:   if (mph_ff == 2'd3) v3_in = msum[64:33];
         ST_LNFIN: lnr_in = ln_full[35:0];
         ST_MSQ:   if (mph_ff == 2'd3) sq_in = msum[71:32];
         ST_MCU:   if (mph_ff == 2'd3) l3_in = msum[75:32];
         ST_MB:    if (mph_ff == 2'd3) tb_in = msum[75:32];
         ST_MC:    if (mph_ff == 2'd3) tc_in = msum[83:32];
         ST_INV: begin
            dvd_in = RECIP_NUM;
            dsr_in = inv_sum;
            rem_in = '0;
            cnt_in = '0;
         end
         ST_TEMP: begin
            if (quo_ff > TEMP_LIMIT_HI) c_in = TEMP_MAX;
            else if (c_diff < 26'(TEMP_MIN)) c_in = TEMP_MIN;
            else c_in = 24'(c_diff);
         end
         ST_FMUL: prod_in = 43'($signed({1'b0, alpha_eff})) * 43'(d_s);
         ST_FADD: begin
            if (y_sum > 28'(TEMP_MAX)) filt_in = TEMP_MAX;
            else if (y_sum < 28'(TEMP_MIN)) filt_in = TEMP_MIN;
            else filt_in = 24'(y_sum);
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_temp_in  = filt_ff[23:7];
               out_res_in   = res_ff;
               out_clamp_in = clamp_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mph_ff       <= '0;
         filt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mph_ff       <= mph_in;
         filt_ff      <= filt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;   res_ff  <= res_in;   clamp_ff <= clamp_in;
      m_ff     <= m_in;     e_ff    <= e_in;     k_ff     <= k_in;
      lnacc_ff <= lnacc_in; v_ff    <= v_in;     v2_ff    <= v2_in;   v3_ff <= v3_in;
      lnr_ff   <= lnr_in;   sq_ff   <= sq_in;    l3_ff    <= l3_in;
      tb_ff    <= tb_in;    tc_ff   <= tc_in;    c_ff     <= c_in;
      prod_ff  <= prod_in;
      dvd_ff   <= dvd_in;   quo_ff  <= quo_in;   rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;   cnt_ff  <= cnt_in;   macc_ff  <= macc_in;
      out_temp_ff  <= out_temp_in;
      out_res_ff   <= out_res_in;
      out_clamp_ff <= out_clamp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_temp  = out_temp_ff;
   assign rsp_res   = out_res_ff;
   assign rsp_clamp = out_clamp_ff;

`ifndef SYNTHESIS
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff)
      else $error("waiting result dropped");
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LNINIT |-> res_ff >= R_MIN && res_ff <= R_MAX)
      else $error("resistance out of range before log");
   a_norm_exp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NORM |-> e_ff >= 5'd6)
      else $error("normalize ran past the resistance floor");
   a_fifo_rd: assert property (@(posedge clock) disable iff (reset)
      fifo_rd |-> !fifo_empty && state_ff == ST_IDLE)
      else $error("queue read while empty or busy");
`endif

endmodule

### hdl/thermistor_temperature_chain_unit.sv
// ----------------------------------------------------------------------------
// thermistor_temperature_chain_unit
// Windowed thermistor divider voltage to filtered Celsius temperature.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue: drive req_sample_mv with push; a transaction completes when
//    push is high and full is low. The front stores the sample in a WINDOW
//    deep shift line, updates the running sum and, once the window holds
//    WINDOW samples, queues the sum (4 entries) for the back end.
//  - Result queue: while empty is low the oldest result is on rsp_*; pop
//    takes it. A stalled receiver only holds the back end in its output
//    state; the front keeps taking samples until its queue fills.
//  - The back end works on one sum at a time: two 64-step shift-subtract
//    divides dominate, plus 1 to 14 normalize steps (set by the resistance
//    bit length), 8 log steps and seven multiplies of four partial products
//    each. A mean at or above supply skips the first divide; a zero sum of the
//    Steinhart-Hart terms skips the second divide and the filter. It reads the
//    next sum only once the current result has left its output state.
//  - Configuration: APB style, 64-bit data, register i at byte address 8*i,
//    pready always high. Write only while idle.
//  - Reset (synchronous) empties the window, the queue and the output and
//    sets the filter state to zero and the registers to their defaults.
// ----------------------------------------------------------------------------
module thermistor_temperature_chain_unit import tcu_pkg::*; #(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // input queue
   input  logic                   push,
   output logic                   full,
   input  logic [SAMPLE_BITS-1:0] req_sample_mv,
   // result queue
   output logic                   empty,
   input  logic                   pop,
   output logic signed [16:0]     rsp_temperature_q8,
   output logic [19:0]            rsp_resistance_ohms,
   output logic                   rsp_clamped,
   // configuration
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CFG_ADDR_W-1:0]  paddr,
   input  logic [63:0]            pwdata,
   output logic [63:0]            prdata,
   output logic                   pready
);

   // sum of a full window: sample width plus growth
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW + 1);

   cfg_type          cfg_ff, cfg_in;
   logic             cfg_wr;
   logic [2:0]       reg_idx;

   logic             q_wr, q_full, q_rd, q_empty;
   logic [SUM_W-1:0] q_wdata, q_rdata;
   logic             rsp_valid;
   logic [16:0]      rsp_temp;

   // ---------------- configuration registers ----------------
   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_idx)
            REG_SUPPLY:  cfg_in.supply_mv    = pwdata[11:0];
            REG_SERIES:  cfg_in.series_ohms  = pwdata[19:0];
            REG_COEFF_A: cfg_in.coeff_a      = pwdata[39:0];
            REG_COEFF_B: cfg_in.coeff_b      = pwdata[39:0];
            REG_COEFF_C: cfg_in.coeff_c      = pwdata[39:0];
            REG_ALPHA:   cfg_in.filter_alpha = pwdata[16:0];
            default:     ;  // unmapped index, write ignored
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SUPPLY:  prdata = 64'(cfg_ff.supply_mv);
         REG_SERIES:  prdata = 64'(cfg_ff.series_ohms);
         REG_COEFF_A: prdata = 64'(cfg_ff.coeff_a);
         REG_COEFF_B: prdata = 64'(cfg_ff.coeff_b);
         REG_COEFF_C: prdata = 64'(cfg_ff.coeff_c);
         REG_ALPHA:   prdata = 64'(cfg_ff.filter_alpha);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.supply_mv    <= SUPPLY_RST;
         cfg_ff.series_ohms  <= SERIES_RST;
         cfg_ff.coeff_a      <= COEFF_A_RST;
         cfg_ff.coeff_b      <= COEFF_B_RST;
         cfg_ff.coeff_c      <= COEFF_C_RST;
         cfg_ff.filter_alpha <= ALPHA_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- front: window and running sum ----------------
   tcu_front #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .sample     (req_sample_mv),
      .queue_full (q_full),
      .queue_wr   (q_wr),
      .queue_data (q_wdata)
   );

   assign full = q_full;

   // ---------------- queue of window sums ----------------
   tcu_fifo #(
      .WIDTH (SUM_W)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_wdata),
      .full    (q_full),
      .rd_en   (q_rd),
      .rd_data (q_rdata),
      .empty   (q_empty)
   );

   // ---------------- back: conversion sequencer ----------------
   tcu_back #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (q_empty),
      .fifo_data  (q_rdata),
      .fifo_rd    (q_rd),
      .rsp_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp_temp   (rsp_temp),
      .rsp_res    (rsp_resistance_ohms),
      .rsp_clamp  (rsp_clamped)
   );

   assign empty              = !rsp_valid;
   assign rsp_temperature_q8 = $signed(rsp_temp);

endmodule
